// ----- rtl/bec_pkg.sv -----
// Package for the biclique extension checker.
// Command codes, fixed field widths and the edge write request type.
// No dependencies.
`default_nettype none

package bec_pkg;

  localparam int VERTEX_W = 6;
  localparam int MAX_ROWS = 64;
  localparam int COUNT_W  = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 12'hFFF;

  typedef enum logic [2:0] {
    FUNC_ADD_EDGE  = 3'd0,
    FUNC_ADD_LEFT  = 3'd1,
    FUNC_ADD_RIGHT = 3'd2,
    FUNC_TEST      = 3'd3,
    FUNC_CLEAR     = 3'd4
  } func_e;

  // Edge write toward the adjacency store: row0 is the first endpoint, row1 the second.
  typedef struct packed {
    logic                en;
    logic [VERTEX_W-1:0] row0;
    logic [VERTEX_W-1:0] row1;
  } edge_wr_t;

endpackage

`default_nettype wire

// ----- rtl/bec_ram.sv -----
// Generic single-port-write, single-port-read RAM with per-bit write mask.
// Read data is registered; a read and a write to the same row return the old data.
// No dependencies.
`default_nettype none

module bec_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wmask_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask_i[i]) begin
          mem_q[waddr_i][i] <= wdata_i[i];
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/bec_adj_store.sv -----
// Adjacency store: two RAMs whose OR gives the symmetric adjacency matrix.
// Row valid bits stand in for a reset clear; one-deep forwarding covers a write that lands on the read edge.
// Depends on bec_pkg and bec_ram.
`default_nettype none

module bec_adj_store
  import bec_pkg::*;
#(
  parameter int ROWS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire logic [VERTEX_W-1:0] raddr_i,
  input  wire edge_wr_t            wr_i,
  output logic      [ROWS-1:0]     row_o
);

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROWS-1:0] ONE = {{(ROWS-1){1'b0}}, 1'b1};

  logic [AW-1:0]   rd_idx, idx_a, idx_b;
  logic [ROWS-1:0] bit_a, bit_b;
  logic [ROWS-1:0] mask0, mask1;
  logic [ROWS-1:0] rd0, rd1;
  logic [ROWS-1:0] vld0_q, vld1_q;
  logic            hit0_q, hit1_q;
  logic [AW-1:0]   ridx_q;
  logic            fwd_en_q;
  logic [AW-1:0]   fwd_a_q, fwd_b_q;
  logic [ROWS-1:0] fwd_row;

  assign rd_idx = raddr_i[AW-1:0];
  assign idx_a  = wr_i.row0[AW-1:0];
  assign idx_b  = wr_i.row1[AW-1:0];
  assign bit_a  = ONE << idx_a;
  assign bit_b  = ONE << idx_b;

  // Edge (a,b) lands in RAM0 row a bit b and RAM1 row b bit a.
  // A row not yet valid is written whole, so stale contents never show.
  assign mask0 = vld0_q[idx_a] ? bit_b : '1;
  assign mask1 = vld1_q[idx_b] ? bit_a : '1;

  bec_ram #(.WIDTH(ROWS), .DEPTH(ROWS)) u_ram0 (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (idx_a),
    .wmask_i (mask0),
    .wdata_i (bit_b),
    .re_i    (load_i),
    .raddr_i (rd_idx),
    .rdata_o (rd0)
  );

  bec_ram #(.WIDTH(ROWS), .DEPTH(ROWS)) u_ram1 (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (idx_b),
    .wmask_i (mask1),
    .wdata_i (bit_a),
    .re_i    (load_i),
    .raddr_i (rd_idx),
    .rdata_o (rd1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q   <= '0;
      vld1_q   <= '0;
      hit0_q   <= 1'b0;
      hit1_q   <= 1'b0;
      fwd_en_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld0_q[idx_a] <= 1'b1;
        vld1_q[idx_b] <= 1'b1;
      end
      if (load_i) begin
        hit0_q   <= vld0_q[rd_idx];
        hit1_q   <= vld1_q[rd_idx];
        // a write on the load edge is missed by the read-first RAM
        fwd_en_q <= wr_i.en;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ridx_q  <= rd_idx;
      fwd_a_q <= idx_a;
      fwd_b_q <= idx_b;
    end
  end

  always_comb begin
    fwd_row = '0;
    if (fwd_en_q && ridx_q == fwd_a_q) begin
      fwd_row = fwd_row | (ONE << fwd_b_q);
    end
    if (fwd_en_q && ridx_q == fwd_b_q) begin
      fwd_row = fwd_row | (ONE << fwd_a_q);
    end
  end

  assign row_o = (hit0_q ? rd0 : '0) | (hit1_q ? rd1 : '0) | fwd_row;

endmodule

`default_nettype wire

// ----- rtl/biclique_extension_checker_top.sv -----
// Top level of the biclique extension checker.
// Command stage, set bitmaps, edge counter and result register; depends on bec_pkg and
// bec_adj_store.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | in        | in_valid_i / in_stall_o    | func_i, vertex_a_i, vertex_b_i
//  out     | out       | out_valid_o / out_stall_i  | edge_added_o, can_extend_o, edge_total_o
//
// One transaction per cycle sustained while the output is not stalled; the accept edge registers the
// command and starts the adjacency RAM row read, and the result register loads once the output is free.
// Reset is asynchronous and clears sets, count, row valid bits and all valid flags at once;
// there is no clearing pass.
// A stalled result holds the command stage; in_stall_o rises in the same cycle.
`default_nettype none

module biclique_extension_checker_top
  import bec_pkg::*;
#(
  parameter int VERTICES = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [2:0]          func_i,
  input  wire logic [VERTEX_W-1:0] vertex_a_i,
  input  wire logic [VERTEX_W-1:0] vertex_b_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     edge_added_o,
  output logic                     can_extend_o,
  output logic [COUNT_W-1:0]       edge_total_o
);

  localparam int ROWS = (VERTICES < MAX_ROWS) ? VERTICES : MAX_ROWS;
  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [VERTEX_W:0] ROWS_LIM = (VERTEX_W + 1)'(ROWS);
  localparam logic [ROWS-1:0] ONE = {{(ROWS-1){1'b0}}, 1'b1};

  logic                s1_valid_q;
  logic [2:0]          func_q;
  logic [VERTEX_W-1:0] va_q, vb_q;

  logic [ROWS-1:0]     left_q, right_q, left_d, right_d;
  logic [COUNT_W-1:0]  count_q, count_d;

  logic                out_valid_q, edge_added_q, can_extend_q;
  logic [COUNT_W-1:0]  edge_total_q;

  logic                out_free, s1_go, load;
  logic [VERTEX_W-1:0] raddr;
  logic [ROWS-1:0]     row;
  edge_wr_t            wr, wr_go;

  logic                ok_a, ok_b, in_sets, cov_l, cov_r, av_l, av_r;
  logic [AW-1:0]       idx_b;
  logic [ROWS-1:0]     bit_b;
  logic                added, extend;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign load       = in_valid_i && !in_stall_o;

  // add edge looks up the first endpoint's row, the candidate test its own row
  assign raddr = (func_i == FUNC_ADD_EDGE) ? vertex_a_i : vertex_b_i;

  assign wr_go = '{en: wr.en && s1_go, row0: wr.row0, row1: wr.row1};

  bec_adj_store #(.ROWS(ROWS)) u_adj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .raddr_i (raddr),
    .wr_i    (wr_go),
    .row_o   (row)
  );

  assign ok_a    = {1'b0, va_q} < ROWS_LIM;
  assign ok_b    = {1'b0, vb_q} < ROWS_LIM;
  assign idx_b   = vb_q[AW-1:0];
  assign bit_b   = ONE << idx_b;
  assign in_sets = |((left_q | right_q) & bit_b);
  assign cov_l   = (left_q & ~row) == '0;
  assign cov_r   = (right_q & ~row) == '0;
  assign av_l    = (left_q & row) == '0;
  assign av_r    = (right_q & row) == '0;

  always_comb begin
    added   = 1'b0;
    extend  = 1'b0;
    left_d  = left_q;
    right_d = right_q;
    count_d = count_q;
    wr      = '0;
    case (func_q)
      FUNC_ADD_EDGE: begin
        if (ok_a && ok_b && !row[idx_b]) begin
          added   = 1'b1;
          wr.en   = 1'b1;
          wr.row0 = va_q;
          wr.row1 = vb_q;
          if (count_q != COUNT_MAX) begin
            count_d = count_q + 1'b1;
          end
        end
      end
      FUNC_ADD_LEFT: begin
        if (ok_b) begin
          left_d = left_q | bit_b;
        end
      end
      FUNC_ADD_RIGHT: begin
        if (ok_b) begin
          right_d = right_q | bit_b;
        end
      end
      FUNC_TEST: begin
        extend = ok_b && !in_sets && ((cov_l && av_r) || (!cov_l && cov_r && av_l));
      end
      FUNC_CLEAR: begin
        left_d  = '0;
        right_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      count_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_go) begin
        left_q  <= left_d;
        right_q <= right_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      func_q <= func_i;
      va_q   <= vertex_a_i;
      vb_q   <= vertex_b_i;
    end
    if (s1_go) begin
      edge_added_q <= added;
      can_extend_q <= extend;
      edge_total_q <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign edge_added_o = edge_added_q;
  assign can_extend_o = can_extend_q;
  assign edge_total_o = edge_total_q;

endmodule

`default_nettype wire

// ----- rtl/bec_checker.sv -----
// Port-level checks for the biclique extension checker, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none

module bec_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        edge_added_o,
  input wire logic        can_extend_o,
  input wire logic [11:0] edge_total_o
);

  logic        out_acc;
  logic [11:0] last_total_q;

  assign out_acc = out_valid_o && !out_stall_i;

  // edge total carried by the last delivered transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_total_q <= '0;
    end else if (out_acc) begin
      last_total_q <= edge_total_o;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(edge_added_o && can_extend_o))
    else $error("edge_added and can_extend both set");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && edge_added_o && last_total_q != 12'hFFF) |-> edge_total_o == last_total_q + 12'd1)
    else $error("new edge did not advance the edge total by one");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !edge_added_o) |-> edge_total_o == last_total_q)
    else $error("edge total changed without a new edge");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output side is free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(edge_total_o)))
    else $error("stalled result dropped or changed");

endmodule

bind biclique_extension_checker_top bec_checker u_bec_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .edge_added_o (edge_added_o),
  .can_extend_o (can_extend_o),
  .edge_total_o (edge_total_o)
);

`default_nettype wire

// ----- test/tb_biclique_extension_checker_top.sv -----
// Testbench for biclique_extension_checker_top: directed and random command streams,
// with a scoreboard class that keeps its own adjacency matrix and set bitmaps.
// Depends on bec_pkg and the checker RTL.
`timescale 1ns / 100ps

module tb_biclique_extension_checker_top;
  import bec_pkg::*;

  localparam int VERTICES     = 64;
  localparam int RANDOM_ITEMS = 950;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic               added;
    logic               extend;
    logic [COUNT_W-1:0] total;
  } status_t;

  class graph_scoreboard;
    logic [MAX_ROWS-1:0] adj_rows [MAX_ROWS];
    logic [MAX_ROWS-1:0] left_bits;
    logic [MAX_ROWS-1:0] right_bits;
    logic [COUNT_W-1:0]  edge_cnt;
    status_t             status_q[$];
    int                  errors;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      left_bits  = '0;
      right_bits = '0;
      edge_cnt   = '0;
      errors     = 0;
    endfunction

    function bit in_range(logic [VERTEX_W-1:0] v);
      return int'(v) < VERTICES;
    endfunction

    // Candidate fails if already a member; otherwise it must fully join one side and
    // fully avoid the other. An empty side satisfies both.
    function bit extends_biclique(logic [VERTEX_W-1:0] v);
      logic [MAX_ROWS-1:0] row;
      if (!in_range(v)) return 1'b0;
      if (left_bits[v] || right_bits[v]) return 1'b0;
      row = adj_rows[v];
      if ((left_bits & ~row) == '0) return (right_bits & row) == '0;
      if ((right_bits & ~row) == '0) return (left_bits & row) == '0;
      return 1'b0;
    endfunction

    function void note_command(logic [2:0] func, logic [VERTEX_W-1:0] a,
                               logic [VERTEX_W-1:0] b);
      status_t next_status;
      next_status = '0;
      case (func)
        FUNC_ADD_EDGE: begin
          if (in_range(a) && in_range(b) && !adj_rows[a][b]) begin
            adj_rows[a][b] = 1'b1;
            adj_rows[b][a] = 1'b1;
            if (edge_cnt != COUNT_MAX) edge_cnt++;
            next_status.added = 1'b1;
          end
        end
        FUNC_ADD_LEFT: begin
          if (in_range(b)) left_bits[b] = 1'b1;
        end
        FUNC_ADD_RIGHT: begin
          if (in_range(b)) right_bits[b] = 1'b1;
        end
        FUNC_TEST: next_status.extend = extends_biclique(b);
        FUNC_CLEAR: begin
          left_bits  = '0;
          right_bits = '0;
        end
        default: ;
      endcase
      next_status.total = edge_cnt;
      status_q = {status_q, next_status};
    endfunction

    function void flag(string what, int want, int got);
      errors++;
      if (errors <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_status(logic added, logic extend, logic [COUNT_W-1:0] total);
      status_t want;
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transaction: edge_added %0d can_extend %0d edge_total %0d",
                   added, extend, total);
        return;
      end
      want = status_q.pop_front();
      if (added !== want.added) flag("edge_added", want.added, added);
      if (extend !== want.extend) flag("can_extend", want.extend, extend);
      if (total !== want.total) flag("edge_total", want.total, total);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [2:0]          func_i = '0;
  logic [VERTEX_W-1:0] vertex_a_i = '0;
  logic [VERTEX_W-1:0] vertex_b_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                edge_added_o;
  logic                can_extend_o;
  logic [COUNT_W-1:0]  edge_total_o;

  graph_scoreboard sb;
  idle_mode_e      idle_mode = IDLE_NONE;
  int              items_sent = 0;
  int              quiet_cycles = 0;

  biclique_extension_checker_top #(.VERTICES(VERTICES)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .vertex_a_i   (vertex_a_i),
    .vertex_b_i   (vertex_b_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .edge_added_o (edge_added_o),
    .can_extend_o (can_extend_o),
    .edge_total_o (edge_total_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int sender_gap_pct(idle_mode_e mode);
    case (mode)
      IDLE_SENDER: return 47;
      IDLE_BOTH:   return 6;
      default:     return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(idle_mode_e mode);
    case (mode)
      IDLE_RECEIVER: return 47;
      IDLE_BOTH:     return 6;
      default:       return 0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct(idle_mode));
  end

  // Both monitors and the watchdog sample pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_command(func_i, vertex_a_i, vertex_b_i);
      if (out_valid_o && !out_stall_i) sb.check_status(edge_added_o, can_extend_o, edge_total_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_cmd(logic [2:0] func, logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b);
    while ($urandom_range(0, 99) < sender_gap_pct(idle_mode)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    vertex_a_i <= a;
    vertex_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  function automatic logic [VERTEX_W-1:0] pick_near(int base);
    return VERTEX_W'(base + $urandom_range(0, 7));
  endfunction

  // One build-and-query sequence on a window of eight vertices so that rows get dense
  // enough for candidates to pass; occasional junk commands mixed in.
  task automatic random_episode();
    int base;
    base = $urandom_range(0, MAX_ROWS - 8);
    if ($urandom_range(0, 3) != 0) send_cmd(FUNC_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom));
    repeat ($urandom_range(0, 6)) send_cmd(FUNC_ADD_EDGE, pick_near(base), pick_near(base));
    repeat ($urandom_range(0, 3)) send_cmd(FUNC_ADD_LEFT, VERTEX_W'($urandom), pick_near(base));
    repeat ($urandom_range(0, 3)) send_cmd(FUNC_ADD_RIGHT, VERTEX_W'($urandom), pick_near(base));
    repeat ($urandom_range(1, 4)) send_cmd(FUNC_TEST, VERTEX_W'($urandom), pick_near(base));
    if ($urandom_range(0, 9) == 0)
      send_cmd(3'($urandom_range(0, 7)), VERTEX_W'($urandom), VERTEX_W'($urandom));
  endtask

  initial begin
    int directed_cnt;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty sets: any candidate passes
    send_cmd(FUNC_TEST, 0, 0);
    send_cmd(FUNC_ADD_EDGE, 0, 63);
    send_cmd(FUNC_ADD_EDGE, 63, 0);
    send_cmd(FUNC_ADD_EDGE, 5, 5);
    send_cmd(FUNC_ADD_EDGE, 5, 5);
    // 11 joins left only, 10 joins right only, 12 joins both, 13 joins neither
    send_cmd(FUNC_ADD_EDGE, 1, 11);
    send_cmd(FUNC_ADD_EDGE, 2, 10);
    send_cmd(FUNC_ADD_EDGE, 1, 12);
    send_cmd(FUNC_ADD_EDGE, 12, 2);
    send_cmd(FUNC_ADD_LEFT, 63, 1);
    send_cmd(FUNC_ADD_RIGHT, 0, 2);
    send_cmd(FUNC_TEST, 0, 11);
    send_cmd(FUNC_TEST, 0, 10);
    send_cmd(FUNC_TEST, 0, 12);
    send_cmd(FUNC_TEST, 0, 13);
    send_cmd(FUNC_TEST, 0, 1);
    send_cmd(FUNC_TEST, 63, 2);
    send_cmd(FUNC_ADD_RIGHT, 0, 63);
    send_cmd(FUNC_TEST, 0, 0);
    send_cmd(3'd5, 63, 63);
    send_cmd(3'd6, 0, 63);
    send_cmd(3'd7, 63, 0);
    send_cmd(FUNC_CLEAR, 63, 63);
    send_cmd(FUNC_TEST, 63, 63);
    directed_cnt = items_sent;

    while (items_sent < directed_cnt + RANDOM_ITEMS) begin
      idle_mode = idle_mode_e'(((items_sent - directed_cnt) / 100) % 4);
      random_episode();
    end
    in_valid_i <= 1'b0;

    while (sb.status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
